[rtl/dbbt_pkg.sv]
// Shared types, widths and codes of the dirty-bucket bitmap tracker.
// Depends on nothing; the top level and dbbt_bitops use it.
`timescale 1ns / 1ps

package dbbt_pkg;

    // Tracked space and write length.
    localparam int TRACKED_ADDR_BITS = 20;
    localparam int MAX_WRITE_LEN     = 64;

    // Port widths of the request and result fields.
    localparam int ADDR_W = 20;
    localparam int LEN_W  = 7;

    // Bitmap geometry: one bit per 4-byte bucket, 32 buckets per word.
    localparam int BKT_SHIFT = 2;
    localparam int WORD_W    = 32;
    localparam int OFF_W     = 5;
    localparam int BUCKET_W  = TRACKED_ADDR_BITS - BKT_SHIFT;
    localparam int WIDX_W    = BUCKET_W - OFF_W;
    localparam int CURSOR_W  = BUCKET_W + 1;
    localparam int NUM_WORDS = 2 ** WIDX_W;
    localparam int SUM_W     = TRACKED_ADDR_BITS + 1;

    typedef logic [ADDR_W-1:0]            addr_t;
    typedef logic [TRACKED_ADDR_BITS-1:0] taddr_t;
    typedef logic [SUM_W-1:0]             sum_t;
    typedef logic [BUCKET_W-1:0]          bucket_t;
    typedef logic [CURSOR_W-1:0]          cursor_t;
    typedef logic [WIDX_W-1:0]            widx_t;
    typedef logic [WORD_W-1:0]            word_t;
    typedef logic [OFF_W-1:0]             off_t;

    // Cursor value one past the last bucket.
    localparam cursor_t CURSOR_END = {1'b1, {BUCKET_W{1'b0}}};

    typedef enum logic [1:0] {
        MODE_MARK    = 2'd0,
        MODE_FETCH   = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_STATUS  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK0,
        ST_MARK1,
        ST_SCAN
    } state_t;

    // Controls from the sequencer to the word logic.
    typedef struct packed {
        off_t  first_off;
        off_t  last_off;
        logic  same_word;
        logic  scan_first;
        off_t  scan_off;
    } bitops_req_t;

    // Word logic results: mark masks and the scan hit.
    typedef struct packed {
        word_t mask0;
        word_t mask1;
        logic  hit;
        off_t  hit_idx;
    } bitops_res_t;

endpackage

[rtl/dirty_bucket_bitmap_tracker_unit.sv]
// Top level of the dirty-bucket bitmap tracker: request sequencer and bitmap store.
// Depends on dbbt_pkg, dbbt_ram and dbbt_bitops.
`timescale 1ns / 1ps

// The tracker keeps one dirty bit per 4-byte bucket of a 1 MiB space in a
// single 8192 x 32 bit synchronous RAM. A request is taken when start is high
// and busy is low, and exactly one result comes back, shown for a single
// cycle with done high; the receiver cannot stall it, so it must take every
// result in the cycle it appears. After reset the block sweeps the whole RAM
// to zero, one word per cycle, and holds busy high, so that no request can be
// taken, until the last word is cleared. A restart, a status request, a mark
// of zero length and a fetch with nothing left at or past the cursor finish
// without a RAM access: their result appears in the cycle after acceptance
// and busy never rises. A mark reads, updates and writes back one or two
// bitmap words through the single read port; the second word is read while
// the first is written back. A fetch reads the word under the scan cursor
// and then one more word per cycle until it meets a set bit; the block keeps
// the highest marked bucket in a register, which bounds the scan and gives
// scan_end for every result without touching the RAM. Fetching never clears
// bits; only reset does.

module dirty_bucket_bitmap_tracker_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             mode,
    input  dbbt_pkg::addr_t        addr,
    input  logic [dbbt_pkg::LEN_W-1:0] len,
    output logic                   done,
    output dbbt_pkg::addr_t        bucket_addr,
    output logic                   found,
    output logic                   scan_end
);

    dbbt_pkg::state_t  state_reg, state_next;
    dbbt_pkg::widx_t   clr_cnt_reg, clr_cnt_next;
    dbbt_pkg::cursor_t cursor_reg, cursor_next;
    dbbt_pkg::bucket_t max_reg, max_next;
    logic              any_reg, any_next;
    logic              done_reg, done_next;

    // Payload registers, no reset needed.
    dbbt_pkg::bucket_t fb_reg, fb_next;
    dbbt_pkg::bucket_t lb_reg, lb_next;
    dbbt_pkg::widx_t   chk_reg, chk_next;
    dbbt_pkg::off_t    off_reg, off_next;
    logic              first_reg, first_next;
    dbbt_pkg::addr_t   baddr_reg, baddr_next;
    logic              found_reg, found_next;
    logic              end_reg, end_next;

    // RAM port signals.
    logic              ram_we;
    dbbt_pkg::widx_t   ram_waddr;
    dbbt_pkg::word_t   ram_wdata;
    logic              ram_re;
    dbbt_pkg::widx_t   ram_raddr;
    dbbt_pkg::word_t   ram_rdata;

    dbbt_pkg::bitops_req_t ops_req;
    dbbt_pkg::bitops_res_t ops;

    // Request decode.
    logic              accept;
    dbbt_pkg::mode_t   req_mode;
    dbbt_pkg::taddr_t  a_in;
    dbbt_pkg::sum_t    len_raw;
    dbbt_pkg::sum_t    len_c;
    dbbt_pkg::sum_t    last_sum;
    dbbt_pkg::taddr_t  last_addr;
    logic              mark_nz;
    dbbt_pkg::bucket_t fb_in;
    dbbt_pkg::bucket_t lb_in;
    logic              empty;
    logic              two_words;
    dbbt_pkg::bucket_t upd_max;
    dbbt_pkg::bucket_t hit_b;

    assign busy     = state_reg != dbbt_pkg::ST_IDLE;
    assign accept   = start && !busy;
    assign req_mode = dbbt_pkg::mode_t'(mode);

    // Address bits above the tracked space drop out here; the length is
    // clamped to the longest write and the range end is clamped to the top.
    assign a_in     = dbbt_pkg::taddr_t'(addr);
    assign len_raw  = dbbt_pkg::sum_t'(len);
    assign len_c    = (len_raw > dbbt_pkg::sum_t'(dbbt_pkg::MAX_WRITE_LEN))
                      ? dbbt_pkg::sum_t'(dbbt_pkg::MAX_WRITE_LEN) : len_raw;
    assign mark_nz  = len_c != '0;
    assign last_sum = dbbt_pkg::sum_t'(a_in) + len_c - dbbt_pkg::sum_t'(1);
    assign last_addr = last_sum[dbbt_pkg::TRACKED_ADDR_BITS]
                       ? '1 : last_sum[dbbt_pkg::TRACKED_ADDR_BITS-1:0];
    assign fb_in    = a_in[dbbt_pkg::TRACKED_ADDR_BITS-1:dbbt_pkg::BKT_SHIFT];
    assign lb_in    = last_addr[dbbt_pkg::TRACKED_ADDR_BITS-1:dbbt_pkg::BKT_SHIFT];

    // Nothing marked at or past the cursor.
    assign empty     = !any_reg || (cursor_reg > dbbt_pkg::cursor_t'(max_reg));
    assign two_words = fb_reg[dbbt_pkg::BUCKET_W-1:dbbt_pkg::OFF_W]
                       != lb_reg[dbbt_pkg::BUCKET_W-1:dbbt_pkg::OFF_W];
    assign upd_max   = (!any_reg || (lb_reg > max_reg)) ? lb_reg : max_reg;
    assign hit_b     = {chk_reg, ops.hit_idx};

    assign ops_req.first_off  = fb_reg[dbbt_pkg::OFF_W-1:0];
    assign ops_req.last_off   = lb_reg[dbbt_pkg::OFF_W-1:0];
    assign ops_req.same_word  = !two_words;
    assign ops_req.scan_first = first_reg;
    assign ops_req.scan_off   = off_reg;

    dbbt_bitops u_bitops (
        .req  (ops_req),
        .data (ram_rdata),
        .res  (ops)
    );

    dbbt_ram #(
        .WIDTH (dbbt_pkg::WORD_W),
        .DEPTH (dbbt_pkg::NUM_WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin : next_state_logic
        state_next = state_reg;
        case (state_reg)
            dbbt_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = dbbt_pkg::ST_IDLE;
                end
            end
            dbbt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_mode == dbbt_pkg::MODE_MARK && mark_nz)
                    begin
                        state_next = dbbt_pkg::ST_MARK0;
                    end
                    else if (req_mode == dbbt_pkg::MODE_FETCH && !empty)
                    begin
                        state_next = dbbt_pkg::ST_SCAN;
                    end
                end
            end
            dbbt_pkg::ST_MARK0:
            begin
                state_next = two_words ? dbbt_pkg::ST_MARK1 : dbbt_pkg::ST_IDLE;
            end
            dbbt_pkg::ST_MARK1:
            begin
                state_next = dbbt_pkg::ST_IDLE;
            end
            dbbt_pkg::ST_SCAN:
            begin
                if (ops.hit)
                begin
                    state_next = dbbt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dbbt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin : output_logic
        ram_we       = 1'b0;
        ram_waddr    = clr_cnt_reg;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = fb_in[dbbt_pkg::BUCKET_W-1:dbbt_pkg::OFF_W];
        clr_cnt_next = clr_cnt_reg;
        cursor_next  = cursor_reg;
        max_next     = max_reg;
        any_next     = any_reg;
        fb_next      = fb_reg;
        lb_next      = lb_reg;
        chk_next     = chk_reg;
        off_next     = off_reg;
        first_next   = first_reg;
        done_next    = 1'b0;
        baddr_next   = baddr_reg;
        found_next   = found_reg;
        end_next     = end_reg;

        case (state_reg)
            dbbt_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + dbbt_pkg::widx_t'(1);
            end
            dbbt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    baddr_next = '0;
                    found_next = 1'b0;
                    case (req_mode)
                        dbbt_pkg::MODE_MARK:
                        begin
                            fb_next = fb_in;
                            lb_next = lb_in;
                            if (mark_nz)
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = fb_in[dbbt_pkg::BUCKET_W-1:dbbt_pkg::OFF_W];
                            end
                            else
                            begin
                                done_next = 1'b1;
                                end_next  = empty;
                            end
                        end
                        dbbt_pkg::MODE_FETCH:
                        begin
                            if (empty)
                            begin
                                // Nothing left: the cursor parks at the end.
                                cursor_next = dbbt_pkg::CURSOR_END;
                                done_next   = 1'b1;
                                end_next    = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = cursor_reg[dbbt_pkg::BUCKET_W-1:dbbt_pkg::OFF_W];
                                chk_next   = cursor_reg[dbbt_pkg::BUCKET_W-1:dbbt_pkg::OFF_W];
                                off_next   = cursor_reg[dbbt_pkg::OFF_W-1:0];
                                first_next = 1'b1;
                            end
                        end
                        dbbt_pkg::MODE_RESTART:
                        begin
                            cursor_next = '0;
                            done_next   = 1'b1;
                            end_next    = !any_reg;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            end_next  = empty;
                        end
                    endcase
                end
            end
            dbbt_pkg::ST_MARK0:
            begin
                ram_we    = 1'b1;
                ram_waddr = fb_reg[dbbt_pkg::BUCKET_W-1:dbbt_pkg::OFF_W];
                ram_wdata = ram_rdata | ops.mask0;
                any_next  = 1'b1;
                max_next  = upd_max;
                if (two_words)
                begin
                    // The second word is read while the first is written back.
                    ram_re    = 1'b1;
                    ram_raddr = lb_reg[dbbt_pkg::BUCKET_W-1:dbbt_pkg::OFF_W];
                end
                else
                begin
                    done_next = 1'b1;
                    end_next  = cursor_reg > dbbt_pkg::cursor_t'(upd_max);
                end
            end
            dbbt_pkg::ST_MARK1:
            begin
                ram_we    = 1'b1;
                ram_waddr = lb_reg[dbbt_pkg::BUCKET_W-1:dbbt_pkg::OFF_W];
                ram_wdata = ram_rdata | ops.mask1;
                done_next = 1'b1;
                end_next  = cursor_reg > dbbt_pkg::cursor_t'(max_reg);
            end
            dbbt_pkg::ST_SCAN:
            begin
                if (ops.hit)
                begin
                    // The cursor lands one past the hit; the scan has ended
                    // exactly when the hit was the highest marked bucket.
                    cursor_next = dbbt_pkg::cursor_t'(hit_b) + dbbt_pkg::cursor_t'(1);
                    done_next   = 1'b1;
                    found_next  = 1'b1;
                    baddr_next  = dbbt_pkg::addr_t'({hit_b, 2'b00});
                    end_next    = hit_b == max_reg;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = chk_reg + dbbt_pkg::widx_t'(1);
                    chk_next   = chk_reg + dbbt_pkg::widx_t'(1);
                    first_next = 1'b0;
                end
            end
            default:
            begin
                clr_cnt_next = clr_cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dbbt_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            cursor_reg  <= '0;
            max_reg     <= '0;
            any_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            cursor_reg  <= cursor_next;
            max_reg     <= max_next;
            any_reg     <= any_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fb_reg    <= fb_next;
        lb_reg    <= lb_next;
        chk_reg   <= chk_next;
        off_reg   <= off_next;
        first_reg <= first_next;
        baddr_reg <= baddr_next;
        found_reg <= found_next;
        end_reg   <= end_next;
    end

    assign done        = done_reg;
    assign bucket_addr = baddr_reg;
    assign found       = found_reg;
    assign scan_end    = end_reg;

`ifndef SYNTH
    // A scan only reads; the bitmap must not change under it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dbbt_pkg::ST_SCAN) |-> !ram_we)
        else $error("bitmap written during a scan");

    // No result may appear while the bitmap is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dbbt_pkg::ST_CLEAR) |-> !done_reg)
        else $error("result during the clearing sweep");

    // Marks are never undone short of reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        any_reg |=> any_reg)
        else $error("marked flag dropped");

    // The cursor never passes the end of the bitmap.
    assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= dbbt_pkg::CURSOR_END)
        else $error("scan cursor out of range");

    // A found bucket leaves the cursor one bucket past it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |->
        (cursor_reg == dbbt_pkg::cursor_t'(baddr_reg >> dbbt_pkg::BKT_SHIFT)
                       + dbbt_pkg::cursor_t'(1)))
        else $error("cursor does not follow the found bucket");
`endif

endmodule

[rtl/dbbt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module dbbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/dbbt_bitops.sv]
// Word logic of the tracker: bucket masks for a mark and the lowest-set-bit search.
// Depends on dbbt_pkg.
`timescale 1ns / 1ps

module dbbt_bitops (
    input  dbbt_pkg::bitops_req_t req,
    input  dbbt_pkg::word_t       data,
    output dbbt_pkg::bitops_res_t res
);

    dbbt_pkg::word_t ones;
    dbbt_pkg::word_t upper;
    dbbt_pkg::word_t scan_mask;
    dbbt_pkg::word_t masked;
    dbbt_pkg::off_t  idx;

    assign ones  = '1;
    assign upper = ones >> (~req.last_off);

    // The first word runs from the first bucket up to the last one, or to the
    // top of the word when the range continues into the next word.
    assign res.mask0 = (ones << req.first_off) & (req.same_word ? upper : ones);
    assign res.mask1 = upper;

    assign scan_mask = req.scan_first ? (ones << req.scan_off) : ones;
    assign masked    = data & scan_mask;

    always_comb
    begin
        idx = '0;
        for (int i = dbbt_pkg::WORD_W - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                idx = dbbt_pkg::off_t'(i);
            end
        end
    end

    assign res.hit     = masked != '0;
    assign res.hit_idx = idx;

endmodule
